>>> hw/rtl/cht_pkg.sv
// Shared widths, constants and handshake types of the circling heading tracker.
`timescale 1ns / 1ps

package cht_pkg;

   // Field widths
   localparam int HEADING_W = 9;
   localparam int CLIMB_W   = 16;
   localparam int SCALE_W   = 16;
   localparam int SECTOR_W  = 3;
   localparam int VALUE_W   = 8;
   localparam int AVG_W     = 17;
   localparam int TOTAL_W   = 10;
   localparam int CHANGE_W  = 9;

   // Stream packing
   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 1;

   // Divider sizing
   localparam int DVD_W = 18 - 1;
   localparam int DSR_W = 7;
   localparam int CNT_W = 5;
   localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(DVD_W);

   // Register indexes
   localparam logic CSR_CLIMB_SCALE = 1'b0;
   localparam logic CSR_AVG_DIVISOR = 1'b1;

   localparam logic [SCALE_W-1:0] CLIMB_SCALE_RESET = 16'd256;
   localparam logic [DSR_W-1:0]   AVG_DIVISOR_RESET = 7'd4;

   // Sector mapping: floor((heading + 338) / 45) by reciprocal, exact up to 849
   localparam logic [9:0]  SECTOR_BASE  = 10'd338;
   localparam logic [10:0] SECTOR_RECIP = 11'd1457;
   localparam int          RECIP_SHIFT  = 16;

   localparam logic signed [10:0] HALF_TURN     = 11'sd180;
   localparam logic signed [10:0] FULL_TURN     = 11'sd360;
   localparam logic signed [16:0] VALUE_MAX     = 17'sd127;
   localparam logic signed [16:0] VALUE_MIN     = -17'sd126;
   localparam logic signed [10:0] TOTAL_MAX     = 11'sd400;
   localparam logic signed [10:0] TOTAL_MIN     = -11'sd400;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DSR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             finishing;
      logic [DVD_W-1:0] quotient;
   } div_rsp_type;

endpackage

>>> hw/rtl/cht_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module cht_divider
   import cht_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DSR_W-1:0] rem_ff, rem_in;
   logic [DSR_W-1:0] dsr_ff, dsr_in;
   logic [DSR_W:0]   rem_shift;
   logic [DSR_W:0]   rem_diff;
   logic             fits;

   always_comb begin
      rem_shift = {rem_ff, dvd_ff[DVD_W-1]};
      rem_diff  = rem_shift - {1'b0, dsr_ff};
      fits      = rem_shift >= {1'b0, dsr_ff};
      count_in  = count_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      if (div_req.start) begin
         count_in = DIV_STEPS;
         dvd_in   = div_req.dividend;
         rem_in   = '0;
         dsr_in   = div_req.divisor;
      end else if (count_ff != '0) begin
         // shift in one quotient bit, keep the partial remainder below the divisor
         count_in = count_ff - CNT_W'(1);
         dvd_in   = {dvd_ff[DVD_W-2:0], fits};
         rem_in   = fits ? rem_diff[DSR_W-1:0] : rem_shift[DSR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.finishing = (count_ff == CNT_W'(1));
   assign div_rsp.quotient  = dvd_ff;

endmodule

>>> hw/rtl/circling_heading_tracker.sv
// Top level: climb history by heading sector and circling heading-change tracking.
`timescale 1ns / 1ps
// An item with circle_sample set passes capture, setup, 17 divider steps and finish after
//   the transfer; without circle_sample, it passes capture and finish.
// A new item is taken only once the last one has finished, so the bit-serial divider of
//   the average update bounds the throughput. A stalled result holds the next item
//   in its finish step.
// Reset (synchronous, active high): history, previous heading, average and total go to zero,
//   climb_scale_q8 to 256 and average_divisor to 4; the result slot is emptied.

module circling_heading_tracker
   import cht_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   // Input stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // heading_deg[8:0], climb_q8[24:9], zero pad
   input  logic [REQ_USER_W-1:0] req_tuser,  // climb_valid[0], position_valid[1],
                                             // circle_sample[2]

   // Result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // sector_index[2:0], sector_value[10:3],
                                             // average_change_q8[27:11],
                                             // total_change[37:28], zero pad
   output logic [RSP_USER_W-1:0] rsp_tuser,  // sector_written[0]

   // Configuration writes
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [SCALE_W-1:0]    csr_wdata
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CALC  = 3'd1;
   localparam logic [2:0] S_START = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_FIN   = 3'd4;

   logic [2:0] state_ff, state_in;

   // Configuration
   logic [SCALE_W-1:0] scale_ff;
   logic [DSR_W-1:0]   divisor_ff;

   // Captured item
   logic                        climb_valid_ff, position_valid_ff, circle_ff;
   logic [HEADING_W-1:0]        heading_ff;
   logic signed [CLIMB_W-1:0]   climb_ff;

   // Tracker state
   logic signed [VALUE_W-1:0]   history_ff [8];
   logic [HEADING_W-1:0]        prev_heading_ff;
   logic signed [AVG_W-1:0]     avg_ff;
   logic signed [TOTAL_W-1:0]   total_ff;

   // Intermediate results
   logic signed [32:0]          prod_ff, prod_in;
   logic [SECTOR_W-1:0]         sector_ff, sector_in;
   logic signed [CHANGE_W-1:0]  change_ff, change_in;
   logic signed [AVG_W:0]       numer_ff, numer_in;

   // Result slot
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_written_ff;

   // Capture-stage arithmetic
   logic [9:0]             sec_sum;
   logic [20:0]            sec_prod;
   logic [4:0]             sec_quot;
   logic signed [10:0]     diff;

   // Finish-stage arithmetic
   logic signed [16:0]         climb_q;
   logic signed [VALUE_W-1:0]  value;
   logic signed [AVG_W:0]      numer_neg;
   logic signed [AVG_W:0]      quot_signed;
   logic signed [AVG_W:0]      avg_sum;
   logic signed [AVG_W-1:0]    avg_next;
   logic signed [10:0]         total_sum;
   logic signed [10:0]         total_fix;
   logic signed [TOTAL_W-1:0]  total_next;
   logic                       sector_write;
   logic                       slot_free;

   div_req_type div_req;
   div_rsp_type div_rsp;

   cht_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // Capture stage: climb product, sector, wrapped heading change, average numerator
   always_comb begin
      prod_in  = 33'(climb_ff) * 33'($signed({1'b0, scale_ff}));
      sec_sum  = {1'b0, heading_ff} + SECTOR_BASE;
      sec_prod = 21'(sec_sum) * 21'(SECTOR_RECIP);
      sec_quot = sec_prod[RECIP_SHIFT+4:RECIP_SHIFT];
      sector_in = sec_quot[SECTOR_W-1:0] + SECTOR_W'(1);

      diff = $signed({2'b00, heading_ff}) - $signed({2'b00, prev_heading_ff});
      // one correction of a full turn at most
      if (diff > HALF_TURN) begin
         diff = diff - FULL_TURN;
      end else if (diff < -HALF_TURN) begin
         diff = diff + FULL_TURN;
      end
      change_in = diff[CHANGE_W-1:0];
      numer_in  = $signed({change_in[CHANGE_W-1], change_in, 8'h00})
                - $signed({avg_ff[AVG_W-1], avg_ff});
   end

   // Divider request: magnitude of the numerator, zero divisor acts as one
   always_comb begin
      numer_neg        = -numer_ff;
      div_req.start    = (state_ff == S_START);
      div_req.dividend = numer_ff[AVG_W] ? numer_neg[DVD_W-1:0] : numer_ff[DVD_W-1:0];
      div_req.divisor  = (divisor_ff == '0) ? DSR_W'(1) : divisor_ff;
   end

   // Finish stage
   always_comb begin
      // truncate toward zero: round the arithmetic shift up for negative inexact products
      climb_q = prod_ff[32:16] + 17'(prod_ff[32] && (prod_ff[15:0] != '0));
      if (climb_q > VALUE_MAX) begin
         value = VALUE_W'(VALUE_MAX);
      end else if (climb_q < VALUE_MIN) begin
         value = VALUE_W'(VALUE_MIN);
      end else begin
         value = climb_q[VALUE_W-1:0];
      end
      sector_write = climb_valid_ff && position_valid_ff;

      quot_signed = numer_ff[AVG_W] ? -$signed({1'b0, div_rsp.quotient})
                                    : $signed({1'b0, div_rsp.quotient});
      avg_sum  = $signed({avg_ff[AVG_W-1], avg_ff}) + quot_signed;
      avg_next = avg_sum[AVG_W-1:0];

      total_sum = $signed({total_ff[TOTAL_W-1], total_ff})
                + $signed({{2{change_ff[CHANGE_W-1]}}, change_ff});
      // drop the total when it runs against the average's sense
      if ((avg_next > 0 && total_sum < 0) || (avg_next < 0 && total_sum > 0)) begin
         total_fix = '0;
      end else begin
         total_fix = total_sum;
      end
      if (total_fix > TOTAL_MAX) begin
         total_next = TOTAL_MAX[TOTAL_W-1:0];
      end else if (total_fix < TOTAL_MIN) begin
         total_next = TOTAL_MIN[TOTAL_W-1:0];
      end else begin
         total_next = total_fix[TOTAL_W-1:0];
      end
      if (!circle_ff) begin
         avg_next   = avg_ff;
         total_next = total_ff;
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            state_in = circle_ff ? S_START : S_FIN;
         end
         S_START: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_rsp.finishing) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         scale_ff        <= CLIMB_SCALE_RESET;
         divisor_ff      <= AVG_DIVISOR_RESET;
         prev_heading_ff <= '0;
         avg_ff          <= '0;
         total_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            history_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;

         if (csr_wr_en) begin
            case (csr_index)
               CSR_CLIMB_SCALE: scale_ff   <= csr_wdata;
               CSR_AVG_DIVISOR: divisor_ff <= csr_wdata[DSR_W-1:0];
               default: begin
               end
            endcase
         end

         // load a new result, or hold the result until the transfer, then free the slot
         if (state_ff == S_FIN && slot_free) begin
            rsp_valid_ff <= 1'b1;
            avg_ff       <= avg_next;
            total_ff     <= total_next;
            if (circle_ff) begin
               prev_heading_ff <= heading_ff;
            end
            if (sector_write) begin
               history_ff[sector_ff] <= value;
            end
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      // Payload registers
      if (req_tvalid && req_tready) begin
         heading_ff        <= req_tdata[HEADING_W-1:0];
         climb_ff          <= req_tdata[HEADING_W+CLIMB_W-1:HEADING_W];
         climb_valid_ff    <= req_tuser[0];
         position_valid_ff <= req_tuser[1];
         circle_ff         <= req_tuser[2];
      end
      if (state_ff == S_CALC) begin
         prod_ff   <= prod_in;
         sector_ff <= sector_in;
         change_ff <= change_in;
         numer_ff  <= numer_in;
      end
      if (state_ff == S_FIN && slot_free) begin
         rsp_written_ff <= sector_write;
         rsp_data_ff    <= {2'b00, total_next, avg_next,
                            sector_write ? value : VALUE_W'(0),
                            sector_write ? sector_ff : SECTOR_W'(0)};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_written_ff;

endmodule

>>> hw/rtl/cht_checker.sv
// Port-level checks of the circling heading tracker, bound to the top level.
`timescale 1ns / 1ps

module cht_checker
   import cht_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [REQ_USER_W-1:0] req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser,
   input logic                  csr_wr_en,
   input logic                  csr_index,
   input logic [SCALE_W-1:0]    csr_wdata
);

   // reset empties the result slot
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // the block is busy right after a transfer in
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input ready right after a transfer");

   // no sector write reports sector zero and value zero
   a_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[10:0] == 11'd0)
      else $error("sector fields set without a write");

   // the total stays clamped
   a_total_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $signed(rsp_tdata[37:28]) <= 400 && $signed(rsp_tdata[37:28]) >= -400)
      else $error("total change out of range");

endmodule

bind circling_heading_tracker cht_checker u_cht_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_wr_en  (csr_wr_en),
   .csr_index  (csr_index),
   .csr_wdata  (csr_wdata)
);

>>> bench/circling_heading_tracker_test.sv
// Self-checking bench for the circling heading tracker: directed and random flight samples.
`timescale 1ns / 1ps

module circling_heading_tracker_test
   import cht_pkg::*;
();

   // Geometry and limits of the tracker, in plain integers for the predictor
   localparam int TURN_DEG        = 360;
   localparam int HALF_TURN_DEG   = 180;
   localparam int SECTOR_SKEW_DEG = 22;
   localparam int SECTOR_SPAN_DEG = 45;
   localparam int VALUE_CEIL      = 127;
   localparam int VALUE_FLOOR     = -126;
   localparam int TOTAL_LIMIT     = 400;
   localparam int SETTLE_CYCLES   = 24;        // longest latency plus margin
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int PHASE_ITEMS     = 240;

   // One flight sample as it crosses the input stream
   typedef struct packed {
      logic                        climb_valid;
      logic                        position_valid;
      logic [HEADING_W-1:0]        heading;
      logic signed [CLIMB_W-1:0]   climb;
      logic                        circle;
   } flight_sample_type;

   // One result of the result stream
   typedef struct packed {
      logic [SECTOR_W-1:0]         sector_index;
      logic signed [VALUE_W-1:0]   sector_value;
      logic                        sector_written;
      logic signed [AVG_W-1:0]     average_change_q8;
      logic signed [TOTAL_W-1:0]   total_change;
   } sector_report_type;

   // Predicts the report of every accepted sample and checks reports in order.
   class tracker_model;
      logic [SCALE_W-1:0]        climb_scale;
      logic [DSR_W-1:0]          avg_divisor;
      logic signed [VALUE_W-1:0] history [8];
      logic [HEADING_W-1:0]      prior_heading;
      int                        avg_q8;
      int                        turn_total;
      sector_report_type         pending_reports [$];
      int                        faults;

      function new();
         climb_scale   = CLIMB_SCALE_RESET;
         avg_divisor   = AVG_DIVISOR_RESET;
         foreach (history[i]) history[i] = '0;
         prior_heading = '0;
         avg_q8        = 0;
         turn_total    = 0;
         faults        = 0;
      endfunction

      function void write_reg(logic idx, logic [SCALE_W-1:0] value);
         if (idx == CSR_CLIMB_SCALE)
            climb_scale = value;
         else
            avg_divisor = value[DSR_W-1:0];
      endfunction

      function void predict_sample(flight_sample_type s);
         sector_report_type r;
         longint         prod;
         longint         q;
         int             sector;
         int             change;
         int             div;
         r = '0;
         if (s.climb_valid && s.position_valid) begin
            // Q8.8 times Q8.8, truncated toward zero back to whole units
            prod = longint'($signed(s.climb)) * longint'(climb_scale);
            q = prod / 65536;
            if (q > VALUE_CEIL) q = VALUE_CEIL;
            if (q < VALUE_FLOOR) q = VALUE_FLOOR;
            sector = ((int'(s.heading) + TURN_DEG - SECTOR_SKEW_DEG) / SECTOR_SPAN_DEG + 1) % 8;
            history[sector]  = q[7:0];
            r.sector_index   = sector[2:0];
            r.sector_value   = q[7:0];
            r.sector_written = 1'b1;
         end
         if (s.circle) begin
            change = int'(s.heading) - int'(prior_heading);
            div = (avg_divisor == 0) ? 1 : int'(avg_divisor);
            if (change > HALF_TURN_DEG) change -= TURN_DEG;
            if (change < -HALF_TURN_DEG) change += TURN_DEG;
            prior_heading = s.heading;
            avg_q8 += (change * 256 - avg_q8) / div;
            turn_total += change;
            // drop the total when it turns against the average
            if ((avg_q8 > 0 && turn_total < 0) || (avg_q8 < 0 && turn_total > 0))
               turn_total = 0;
            if (turn_total < -TOTAL_LIMIT) turn_total = -TOTAL_LIMIT;
            if (turn_total > TOTAL_LIMIT) turn_total = TOTAL_LIMIT;
         end
         r.average_change_q8 = avg_q8[AVG_W-1:0];
         r.total_change      = turn_total[TOTAL_W-1:0];
         pending_reports.push_back(r);
      endfunction

      function void compare_report(sector_report_type got);
         sector_report_type want;
         if (pending_reports.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("unexpected report: idx=%0d val=%0d wr=%0d avg=%0d total=%0d",
                        got.sector_index, $signed(got.sector_value), got.sector_written,
                        $signed(got.average_change_q8), $signed(got.total_change));
            return;
         end
         want = pending_reports.pop_front();
         if (got.sector_index !== want.sector_index || got.sector_value !== want.sector_value ||
             got.sector_written !== want.sector_written ||
             got.average_change_q8 !== want.average_change_q8 ||
             got.total_change !== want.total_change) begin
            faults++;
            if (faults <= 10)
               $display("mismatch at %0t: expected idx=%0d val=%0d wr=%0d avg=%0d total=%0d",
                        $realtime, want.sector_index, $signed(want.sector_value),
                        want.sector_written, $signed(want.average_change_q8),
                        $signed(want.total_change));
            if (faults <= 10)
               $display("   got idx=%0d val=%0d wr=%0d avg=%0d total=%0d",
                        got.sector_index, $signed(got.sector_value), got.sector_written,
                        $signed(got.average_change_q8), $signed(got.total_change));
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // heading_deg, climb_q8, zero pad
   logic [REQ_USER_W-1:0] req_tuser;   // climb_valid, position_valid, circle_sample
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // sector_index, sector_value, average, total, pad
   logic [RSP_USER_W-1:0] rsp_tuser;   // sector_written
   logic                  csr_wr_en;
   logic                  csr_index;
   logic [SCALE_W-1:0]    csr_wdata;

   tracker_model book;
   bit           full_rate = 1'b0;    // no idling on either side while set
   int           cycle_count = 0;
   int           rx_hold = 0;
   int           course = 0;           // heading of the simulated circling glider

   circling_heading_tracker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Mostly short idle stretches, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Climb rates of every magnitude, so both clamps and the unclamped range get hit
   function automatic logic signed [CLIMB_W-1:0] pick_climb();
      int mag;
      if ($urandom_range(0, 2) == 0) return CLIMB_W'($urandom);
      mag = $urandom_range(0, (1 << $urandom_range(1, 15)) - 1);
      return CLIMB_W'($urandom_range(0, 1) ? -mag : mag);
   endfunction

   function automatic flight_sample_type sample_of(logic cv, logic pv, int heading, int climb,
                                                   logic circ);
      flight_sample_type s;
      s.climb_valid    = cv;
      s.position_valid = pv;
      s.heading        = heading[HEADING_W-1:0];
      s.climb          = climb[CLIMB_W-1:0];
      s.circle         = circ;
      return s;
   endfunction

   // Receive side: check each transfer, then stall at random
   always @(posedge clock) begin : rsp_side
      sector_report_type seen;
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_hold    <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.sector_index      = rsp_tdata[2:0];
            seen.sector_value      = rsp_tdata[10:3];
            seen.sector_written    = rsp_tuser[0];
            seen.average_change_q8 = rsp_tdata[27:11];
            seen.total_change      = rsp_tdata[37:28];
            book.compare_report(seen);
         end
         if (rx_hold > 0) begin
            rsp_tready <= 1'b0;
            rx_hold    <= rx_hold - 1;
         end else begin
            rsp_tready <= 1'b1;
            rx_hold    <= full_rate ? 0 : pick_gap();
         end
      end
   end

   // Offer one sample, hold it until the transfer, then idle for a random gap.
   // With no gap, valid stays high so the next call can follow in the same step.
   task automatic send_sample(flight_sample_type s);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({s.climb, s.heading});
      req_tuser  <= {s.circle, s.position_valid, s.climb_valid};
      do @(posedge clock); while (!req_tready);
      book.predict_sample(s);
      gap = full_rate ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every report is in and the block has gone quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (book.pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leaves csr_wr_en high; the caller lowers it after the last write
   task automatic csr_put(logic idx, logic [SCALE_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      book.write_reg(idx, value);
   endtask

   task automatic program_regs(logic [SCALE_W-1:0] scale, int divisor);
      logic [SCALE_W-1:0] word;
      // junk in the unused upper bits of the divisor write must be ignored
      word = SCALE_W'($urandom);
      word[DSR_W-1:0] = divisor[DSR_W-1:0];
      if ($urandom_range(0, 1)) begin
         csr_put(CSR_CLIMB_SCALE, scale);
         csr_put(CSR_AVG_DIVISOR, word);
      end else begin
         csr_put(CSR_AVG_DIVISOR, word);
         csr_put(CSR_CLIMB_SCALE, scale);
      end
      csr_wr_en <= 1'b0;
   endtask

   // Mostly steady turns with random content; the rest is raw noise
   task automatic run_random(int items);
      flight_sample_type s;
      int sent;
      int run;
      int dir;
      int base;
      int stride;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(0, 99) < 75) begin
            run  = $urandom_range(8, 40);
            if (run > items - sent) run = items - sent;
            dir  = $urandom_range(0, 1) ? 1 : -1;
            base = $urandom_range(0, 45);
            repeat (run) begin
               stride = base + $urandom_range(0, 10) - 5;
               course = (course + dir * stride + 2 * TURN_DEG) % TURN_DEG;
               s.heading = ($urandom_range(0, 19) == 0) ? HEADING_W'($urandom_range(360, 511))
                                                        : HEADING_W'(course);
               s.climb_valid    = ($urandom_range(0, 9) != 0);
               s.position_valid = ($urandom_range(0, 9) != 0);
               s.circle         = ($urandom_range(0, 6) != 0);
               s.climb          = pick_climb();
               send_sample(s);
            end
         end else begin
            run = $urandom_range(1, 6);
            if (run > items - sent) run = items - sent;
            repeat (run) begin
               s.heading        = HEADING_W'($urandom_range(0, 511));
               s.climb_valid    = 1'($urandom_range(0, 1));
               s.position_valid = 1'($urandom_range(0, 1));
               s.circle         = 1'($urandom_range(0, 1));
               s.climb          = CLIMB_W'($urandom);
               send_sample(s);
            end
         end
         sent += run;
      end
   endtask

   initial begin
      book = new();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_wr_en  <= 1'b0;
      csr_index  <= CSR_CLIMB_SCALE;
      csr_wdata  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset settings: validity gating, clamps, truncation
      // toward zero and sector borders
      send_sample(sample_of(0, 0,   0,      0, 0));
      send_sample(sample_of(1, 0, 100,   1000, 0));
      send_sample(sample_of(0, 1, 100,   1000, 0));
      send_sample(sample_of(1, 1,   0,  32767, 0));
      send_sample(sample_of(1, 1,  21, -32768, 0));
      send_sample(sample_of(1, 1,  22,     -1, 0));
      send_sample(sample_of(1, 1, 359,   -257, 0));
      send_sample(sample_of(1, 1, 511,    256, 0));
      send_sample(sample_of(1, 1,  67,  32512, 0));
      send_sample(sample_of(1, 1, 336, -32256, 0));
      // Heading changes: wrap both ways, out-of-range headings, the half-turn edges
      send_sample(sample_of(1, 1,  10,    512, 1));
      send_sample(sample_of(0, 0, 350,      0, 1));
      send_sample(sample_of(0, 1, 190,      0, 1));
      send_sample(sample_of(1, 0,   0,      0, 1));
      send_sample(sample_of(1, 1, 511,   -512, 1));
      send_sample(sample_of(0, 0,   0,      0, 1));
      send_sample(sample_of(0, 0, 180,      0, 1));
      send_sample(sample_of(0, 0,   0,      0, 1));
      send_sample(sample_of(0, 0, 360,      0, 1));
      // Steady right turn: drive the total into its upper clamp
      for (int k = 1; k <= 6; k++)
         send_sample(sample_of(1, 1, (k * 90) % TURN_DEG, 300 * k, 1));

      // Random phases, each under its own register setting, written while idle
      for (int phase = 0; phase < 8; phase++) begin
         settle();
         full_rate = 1'b0;
         case (phase)
            0: program_regs(16'd256, 1);
            1: program_regs(16'd0, 64);
            2: program_regs(16'hFFFF, 0);
            3: program_regs(SCALE_W'($urandom), 127);
            4: program_regs(16'd1, $urandom_range(1, 64));
            5: program_regs(SCALE_W'($urandom), $urandom_range(0, 127));
            6: begin
               program_regs(16'd128, 2);
               full_rate = 1'b1;
            end
            default: program_regs(SCALE_W'($urandom), $urandom_range(1, 64));
         endcase
         run_random(PHASE_ITEMS);
      end

      // Let the last reports drain, then judge
      settle();
      if (book.faults == 0 && book.pending_reports.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
